/* design/ray_disc_intersection_top_macros.svh */
// assertion macros for the ray disc intersection block
`ifndef RAY_DISC_INTERSECTION_TOP_MACROS_SVH
`define RAY_DISC_INTERSECTION_TOP_MACROS_SVH
`ifndef SYNTH
`define RDI_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define RDI_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define RDI_ASSERT(label, clk, rst_n, prop, msg)
`define RDI_ASSERT_NEXT(label, clk, rst_n, pre, post, msg)
`endif
`endif

/* design/rdi_pkg.sv */
// package with payload types and constants of the ray disc intersection block
package rdi_pkg;
	typedef struct packed {
		logic signed [31:0] origin_x;
		logic signed [31:0] origin_y;
		logic signed [31:0] origin_z;
		logic signed [31:0] dir_x;
		logic signed [31:0] dir_y;
		logic signed [31:0] dir_z;
		logic signed [31:0] near_limit;
		logic signed [31:0] far_limit;
	} ray_t;

	typedef struct packed {
		logic               hit;
		logic signed [31:0] hit_distance;
		logic signed [31:0] entry_x;
		logic signed [31:0] entry_y;
		logic signed [31:0] entry_z;
		logic               normal_flipped;
	} result_t;

	typedef enum logic [2:0] {
		REG_NORMAL_X  = 3'd0,
		REG_NORMAL_Y  = 3'd1,
		REG_NORMAL_Z  = 3'd2,
		REG_CENTER_X  = 3'd3,
		REG_CENTER_Y  = 3'd4,
		REG_CENTER_Z  = 3'd5,
		REG_RADIUS    = 3'd6,
		REG_TWO_SIDED = 3'd7
	} reg_idx_t;

	localparam int CFG_IDX_W = 4;
	localparam logic signed [31:0] SAT_MAX = 32'sh7fffffff;
	localparam logic signed [31:0] SAT_MIN = 32'sh80000000;
endpackage

/* design/rdi_divider.sv */
// pipelined restoring divider for the plane distance, one quotient bit per stage
module rdi_divider import rdi_pkg::*; #(
	parameter int NUM_W = 52,
	parameter int DEN_W = 52,
	parameter int Q_W = 33,
	parameter int TAG_W = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_valid,
	input  logic [NUM_W-1:0] in_num,
	input  logic [DEN_W-1:0] in_den,
	input  logic [TAG_W-1:0] in_tag,
	output logic             out_valid,
	output logic [Q_W-1:0]   out_quot,
	output logic [TAG_W-1:0] out_tag
);
	// one stage per quotient bit, msb first; remainder kept one bit wider than divisor
	logic             v_s   [Q_W+1];
	logic [DEN_W:0]   rem_s [Q_W+1];
	logic [NUM_W-1:0] num_s [Q_W+1];
	logic [DEN_W-1:0] den_s [Q_W+1];
	logic [Q_W-1:0]   q_s   [Q_W+1];
	logic [TAG_W-1:0] tag_s [Q_W+1];

	assign v_s[0]   = in_valid;
	assign rem_s[0] = '0;
	assign num_s[0] = in_num;
	assign den_s[0] = in_den;
	assign q_s[0]   = '0;
	assign tag_s[0] = in_tag;

	for (genvar i = 0; i < Q_W; i++) begin : g_stage
		logic [DEN_W+1:0] trial;
		logic [DEN_W+1:0] shifted;
		logic             nbit;
		// the numerator is consumed msb first; bits beyond it are zero
		always_comb begin
			nbit = (i < NUM_W) ? num_s[i][NUM_W-1] : 1'b0;
			shifted = {rem_s[i], nbit};
			trial = shifted - {1'b0, 1'b0, den_s[i]};
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i+1] <= 1'b0;
			end else if (en) begin
				v_s[i+1] <= v_s[i];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				num_s[i+1] <= num_s[i] << 1;
				den_s[i+1] <= den_s[i];
				tag_s[i+1] <= tag_s[i];
				if (!trial[DEN_W+1]) begin
					rem_s[i+1] <= trial[DEN_W:0];
					q_s[i+1]   <= {q_s[i][Q_W-2:0], 1'b1};
				end else begin
					rem_s[i+1] <= shifted[DEN_W:0];
					q_s[i+1]   <= {q_s[i][Q_W-2:0], 1'b0};
				end
			end
		end
	end

	assign out_valid = v_s[Q_W];
	assign out_quot  = q_s[Q_W];
	assign out_tag   = tag_s[Q_W];
endmodule

/* design/ray_disc_intersection_top.sv */
// ray disc intersection: a pipeline taking one ray per cycle unless stalled
//
// usage:
//   rays enter on in_valid/in_stall/in_data; results leave on
//   out_valid/out_stall/out_data, one result transaction per ray, in order.
//   the disc (normal, center, radius, two_sided) is written on the
//   cfg channel (cfg_valid/cfg_ready, cfg_index, cfg_data); cfg_ready is
//   always high; user must write only while no ray is in flight; unchecked.
// depth: 2 + 69 + 4 = 75 register stages from the input transaction to
//   out_valid (dot products, a 69 stage bit-per-stage divider,
//   entry point and distance check).
// throughput: one ray per cycle unless stalled; the divider's
//   one-bit-per-stage chain sets the depth but not the rate.
// reset: arst_n clears all valid bits and loads the default disc (unit z
//   normal at the origin, radius 1.0, one-sided).
// stall: while the last stage holds a result and out_stall is high the
//   whole pipeline freezes in place and in_stall is high; no stage moves
//   then, so bubbles inside the pipe are not squeezed out.
`include "ray_disc_intersection_top_macros.svh"
module ray_disc_intersection_top import rdi_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  ray_t                 in_data,
	output logic                 out_valid,
	input  logic                 out_stall,
	output result_t              out_data,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]          cfg_data
);
	localparam int ONE = 1 << FRAC_BITS;
	// |num| < 3*2^17*2^33: 53 bits magnitude; quotient of (|num|<<F)/|nd|
	localparam int MAG_W = 53;
	localparam int NUM_W = MAG_W + FRAC_BITS;
	localparam int DEN_W = 52;
	localparam int Q_W = NUM_W;
	localparam int TAG_W = 1 + 1 + 32 * 8;

	// configuration registers
	logic signed [17:0] normal_x_q, normal_y_q, normal_z_q;
	logic signed [31:0] center_x_q, center_y_q, center_z_q;
	logic [30:0]        radius_q;
	logic               two_sided_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			normal_x_q  <= '0;
			normal_y_q  <= '0;
			normal_z_q  <= 18'(ONE);
			center_x_q  <= '0;
			center_y_q  <= '0;
			center_z_q  <= '0;
			radius_q    <= 31'(ONE);
			two_sided_q <= 1'b0;
		end else if (cfg_valid && cfg_ready && cfg_index < CFG_IDX_W'(8)) begin
			unique case (reg_idx_t'(cfg_index[2:0]))
				REG_NORMAL_X:  normal_x_q  <= cfg_data[17:0];
				REG_NORMAL_Y:  normal_y_q  <= cfg_data[17:0];
				REG_NORMAL_Z:  normal_z_q  <= cfg_data[17:0];
				REG_CENTER_X:  center_x_q  <= cfg_data;
				REG_CENTER_Y:  center_y_q  <= cfg_data;
				REG_CENTER_Z:  center_z_q  <= cfg_data;
				REG_RADIUS:    radius_q    <= cfg_data[30:0];
				REG_TWO_SIDED: two_sided_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// global advance: the whole pipe moves unless a finished result is held
	logic en;
	assign en = !(out_valid && out_stall);
	assign in_stall = !en;

	// stage 1: per-axis products for both dot products
	logic               v_s1;
	ray_t               ray_s1;
	logic signed [49:0] pd_x_s1, pd_y_s1, pd_z_s1;
	logic signed [50:0] pn_x_s1, pn_y_s1, pn_z_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (en) v_s1 <= in_valid;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			ray_s1  <= in_data;
			pd_x_s1 <= 50'(normal_x_q * in_data.dir_x);
			pd_y_s1 <= 50'(normal_y_q * in_data.dir_y);
			pd_z_s1 <= 50'(normal_z_q * in_data.dir_z);
			pn_x_s1 <= 51'(normal_x_q * (33'(center_x_q) - 33'(in_data.origin_x)));
			pn_y_s1 <= 51'(normal_y_q * (33'(center_y_q) - 33'(in_data.origin_y)));
			pn_z_s1 <= 51'(normal_z_q * (33'(center_z_q) - 33'(in_data.origin_z)));
		end
	end

	// stage 2: sums, facing test and divider operand magnitudes
	logic               v_s2;
	ray_t               ray_s2;
	logic               pass_s2, neg_s2, flip_s2;
	logic [MAG_W-1:0]   anum_s2;
	logic [DEN_W-1:0]   aden_s2;
	logic signed [51:0] nd_c;
	logic signed [53:0] num_c;

	always_comb begin
		nd_c  = 52'(pd_x_s1) + 52'(pd_y_s1) + 52'(pd_z_s1);
		num_c = 54'(pn_x_s1) + 54'(pn_y_s1) + 54'(pn_z_s1);
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (en) v_s2 <= v_s1;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			ray_s2  <= ray_s1;
			pass_s2 <= (nd_c != 0) && (nd_c < 0 || two_sided_q);
			flip_s2 <= nd_c < 0;
			neg_s2  <= (num_c < 0) != (nd_c < 0);
			anum_s2 <= MAG_W'(num_c < 0 ? -num_c : num_c);
			aden_s2 <= DEN_W'(nd_c < 0 ? -nd_c : nd_c);
		end
	end

	// stage 3..: divider carries the ray and flags as a tag
	logic             dv;
	logic [Q_W-1:0]   dq;
	logic [TAG_W-1:0] dtag;

	logic             neg_d;
	logic [TAG_W-1:0] tag_pack;
	assign tag_pack = {pass_s2, flip_s2, ray_s2};

	logic [TAG_W:0] dtag_neg;
	// the sign of t rides as the top bit of the tag
	rdi_divider #(
		.NUM_W(NUM_W), .DEN_W(DEN_W), .Q_W(Q_W), .TAG_W(TAG_W + 1)
	) u_div (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(v_s2),
		.in_num({anum_s2, FRAC_BITS'(0)}),
		.in_den(aden_s2),
		.in_tag({neg_s2, tag_pack}),
		.out_valid(dv),
		.out_quot(dq),
		.out_tag(dtag_neg)
	);
	assign neg_d = dtag_neg[TAG_W];
	assign dtag  = dtag_neg[TAG_W-1:0];

	// stage 4: saturate t, range test, scale products
	ray_t               dray;
	logic               dpass, dflip;
	logic signed [31:0] t_c;
	assign dray  = ray_t'(dtag[255:0]);
	assign dflip = dtag[256];
	assign dpass = dtag[257];

	always_comb begin
		if (neg_d) begin
			t_c = (dq >= Q_W'(64'h80000000)) ? SAT_MIN : -32'(dq);
		end else begin
			t_c = (dq > Q_W'(64'h7fffffff)) ? SAT_MAX : 32'(dq);
		end
	end

	logic               v_s4, pass_s4, flip_s4;
	ray_t               ray_s4;
	logic signed [31:0] t_s4;
	logic signed [63:0] mx_s4, my_s4, mz_s4;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s4 <= 1'b0;
		else if (en) v_s4 <= dv;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			ray_s4  <= dray;
			flip_s4 <= dflip;
			t_s4    <= t_c;
			pass_s4 <= dpass && (t_c > dray.near_limit) && (t_c <= dray.far_limit);
			mx_s4   <= dray.dir_x * t_c;
			my_s4   <= dray.dir_y * t_c;
			mz_s4   <= dray.dir_z * t_c;
		end
	end

	// stage 5: entry point (shift rounds toward minus infinity) and offset
	logic               v_s5, pass_s5, flip_s5;
	logic signed [31:0] t_s5;
	logic signed [47:0] px_s5, py_s5, pz_s5;
	logic signed [48:0] lx_s5, ly_s5, lz_s5;
	logic signed [47:0] px_c, py_c, pz_c;
	always_comb begin
		px_c = 48'(ray_s4.origin_x) + 48'(mx_s4 >>> FRAC_BITS);
		py_c = 48'(ray_s4.origin_y) + 48'(my_s4 >>> FRAC_BITS);
		pz_c = 48'(ray_s4.origin_z) + 48'(mz_s4 >>> FRAC_BITS);
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s5 <= 1'b0;
		else if (en) v_s5 <= v_s4;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			pass_s5 <= pass_s4;
			flip_s5 <= flip_s4;
			t_s5    <= t_s4;
			px_s5   <= px_c;
			py_s5   <= py_c;
			pz_s5   <= pz_c;
			lx_s5   <= 49'(px_c) - 49'(center_x_q);
			ly_s5   <= 49'(py_c) - 49'(center_y_q);
			lz_s5   <= 49'(pz_c) - 49'(center_z_q);
		end
	end

	// stage 6: absolute offsets, box check and squares
	logic [47:0] ax_c, ay_c, az_c;
	always_comb begin
		ax_c = 48'(lx_s5 < 0 ? -lx_s5 : lx_s5);
		ay_c = 48'(ly_s5 < 0 ? -ly_s5 : ly_s5);
		az_c = 48'(lz_s5 < 0 ? -lz_s5 : lz_s5);
	end
	logic               v_s6, pass_s6, flip_s6;
	logic signed [31:0] t_s6;
	logic signed [47:0] px_s6, py_s6, pz_s6;
	logic [61:0]        sx_s6, sy_s6, sz_s6, rr_s6;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s6 <= 1'b0;
		else if (en) v_s6 <= v_s5;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			pass_s6 <= pass_s5 && ax_c <= 48'(radius_q) && ay_c <= 48'(radius_q)
				&& az_c <= 48'(radius_q);
			flip_s6 <= flip_s5;
			t_s6    <= t_s5;
			px_s6   <= px_s5;
			py_s6   <= py_s5;
			pz_s6   <= pz_s5;
			sx_s6   <= 62'(ax_c[30:0]) * 62'(ax_c[30:0]);
			sy_s6   <= 62'(ay_c[30:0]) * 62'(ay_c[30:0]);
			sz_s6   <= 62'(az_c[30:0]) * 62'(az_c[30:0]);
			rr_s6   <= 62'(radius_q) * 62'(radius_q);
		end
	end

	// stage 7: disc test and output register
	function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
		if (v > 48'(SAT_MAX)) return SAT_MAX;
		if (v < 48'(SAT_MIN)) return SAT_MIN;
		return v[31:0];
	endfunction

	logic    hit_c;
	assign hit_c = pass_s6 && (64'(sx_s6) + 64'(sy_s6) + 64'(sz_s6) <= 64'(rr_s6));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (en) out_valid <= v_s6;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			out_data.hit            <= hit_c;
			out_data.hit_distance   <= hit_c ? t_s6 : '0;
			out_data.entry_x        <= hit_c ? sat32(px_s6) : '0;
			out_data.entry_y        <= hit_c ? sat32(py_s6) : '0;
			out_data.entry_z        <= hit_c ? sat32(pz_s6) : '0;
			out_data.normal_flipped <= hit_c && flip_s6;
		end
	end

	`RDI_ASSERT(a_stall_hold, clk, arst_n, !(in_stall && !(out_valid && out_stall)), "stall without held result")
	`RDI_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(out_data), "held result changed")
	`RDI_ASSERT(a_miss_zero, clk, arst_n, !(out_valid && !out_data.hit) || (out_data.hit_distance == 0 && !out_data.normal_flipped), "miss carries data")
endmodule
